>>> design/circle_event_point_core_macros.svh
// ---------------------------------------------------------------------------
// Circle event point core - assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_EVENT_POINT_CORE_MACROS_SVH
`define CIRCLE_EVENT_POINT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cep_pkg.sv
// ---------------------------------------------------------------------------
// Circle event point package
// Widths, command and status types and the output clamp shared by the core.
// ---------------------------------------------------------------------------
package cep_pkg;

    localparam int SITE_COUNT = 256;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // Fixed port widths
    localparam int IDX_BITS  = 8;
    localparam int LOAD_BITS = 16;
    localparam int OUT_BITS  = 32;

    localparam int ADDR_BITS = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;

    // Datapath widths, all following from the coordinate and fraction widths
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SUMSQ_W = 2 * COORD_BITS + 1;
    localparam int ACC_W   = SUMSQ_W + DIFF_W;
    localparam int DEN_W   = 2 * COORD_BITS + 4;
    localparam int NUM_W   = ACC_W + FRAC_BITS;
    localparam int QUO_W   = NUM_W + 1;
    localparam int EXT_W   = QUO_W + 1;
    localparam int MAG_W   = QUO_W;
    localparam int RAD_W   = 2 * QUO_W + 2;
    localparam int ROOT_W  = QUO_W + 1;
    localparam int REM_W   = QUO_W + 4;
    localparam int BOT_W   = QUO_W + 2;

    // Sequencer step counts
    localparam int SITE_READS = 3;
    localparam int READ_STEPS = SITE_READS + 1;
    localparam int MAC_STEPS  = 12;
    localparam int DIV_STEPS  = NUM_W;
    localparam int SQ_STEPS   = MAG_W;
    localparam int RT_STEPS   = ROOT_W;
    localparam int CNT_W      = $clog2(RT_STEPS + 1);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SITE_FIRST  = 2'd0,
        SITE_SECOND = 2'd1,
        SITE_THIRD  = 2'd2
    } site_sel_t;

    // Multiply-accumulate schedule: pairs of products per stored term
    typedef enum logic [3:0] {
        MAC_S1A = 4'd0,
        MAC_S1B = 4'd1,
        MAC_S2A = 4'd2,
        MAC_S2B = 4'd3,
        MAC_DFA = 4'd4,
        MAC_DFB = 4'd5,
        MAC_DGA = 4'd6,
        MAC_DGB = 4'd7,
        MAC_NFA = 4'd8,
        MAC_NFB = 4'd9,
        MAC_NGA = 4'd10,
        MAC_NGB = 4'd11
    } mac_op_t;

    typedef struct packed {
        logic      load_we;
        logic      latch_idx;
        logic      rd_en;
        site_sel_t rd_site;
        logic      cap_en;
        site_sel_t cap_site;
        logic      mac_en;
        mac_op_t   mac_op;
        logic      div_init;
        logic      div_step;
        logic      hk_load;
        logic      sq_init;
        logic      sq_step;
        logic      rt_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic degen;
    } status_t;

    // Returns {clamped, value}
    function automatic logic [OUT_BITS:0] clamp_out(input logic signed [BOT_W-1:0] v);
        logic [BOT_W-OUT_BITS:0] top;
        logic [OUT_BITS:0]       res;
        top = v[BOT_W-1:OUT_BITS-1];
        if (top == '0 || top == '1) begin
            res = {1'b0, v[OUT_BITS-1:0]};
        end
        else if (v[BOT_W-1]) begin
            res = {1'b1, 1'b1, {(OUT_BITS-1){1'b0}}};
        end
        else begin
            res = {1'b1, 1'b0, {(OUT_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> design/cep_ctrl.sv
// ---------------------------------------------------------------------------
// Circle event point controller
// Handshake control and the step sequencer driving the datapath.
// ---------------------------------------------------------------------------
module cep_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                operation,
    input  logic                out_stall,
    input  cep_pkg::status_t    status,
    output logic                in_stall,
    output logic                out_valid,
    output cep_pkg::cmd_t       cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_READ  = 10'b0000000010,
        ST_MAC   = 10'b0000000100,
        ST_CHECK = 10'b0000001000,
        ST_DIV   = 10'b0000010000,
        ST_HK    = 10'b0000100000,
        ST_SQI   = 10'b0001000000,
        ST_SQR   = 10'b0010000000,
        ST_ROOT  = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [cep_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        accept;
    logic                        out_free;
    logic [1:0]                  cap_code;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cap_code  = cnt_reg[1:0] - 2'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd        = '0;
        cmd.rd_site  = cep_pkg::SITE_FIRST;
        cmd.cap_site = cep_pkg::SITE_FIRST;
        cmd.mac_op   = cep_pkg::MAC_S1A;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (operation == cep_pkg::OP_EVAL) begin
                        cmd.latch_idx = 1'b1;
                        state_next    = ST_READ;
                    end
                    else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (cnt_reg < cep_pkg::CNT_W'(cep_pkg::SITE_READS)) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_site = cep_pkg::site_sel_t'(cnt_reg[1:0]);
                end
                if (cnt_reg != '0) begin
                    cmd.cap_en   = 1'b1;
                    cmd.cap_site = cep_pkg::site_sel_t'(cap_code);
                end
                if (cnt_reg == cep_pkg::CNT_W'(cep_pkg::READ_STEPS - 1)) begin
                    state_next = ST_MAC;
                end
                else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_op = cep_pkg::mac_op_t'(cnt_reg[3:0]);
                if (cnt_reg == cep_pkg::CNT_W'(cep_pkg::MAC_STEPS - 1)) begin
                    state_next = ST_CHECK;
                end
                else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                // collinear or repeated sites skip straight to the result
                if (status.degen) begin
                    state_next = ST_FIN;
                end
                else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == cep_pkg::CNT_W'(cep_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_HK;
                end
                else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HK:
            begin
                cmd.hk_load = 1'b1;
                state_next  = ST_SQI;
            end
            ST_SQI:
            begin
                cmd.sq_init = 1'b1;
                state_next  = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == cep_pkg::CNT_W'(cep_pkg::SQ_STEPS - 1)) begin
                    state_next = ST_ROOT;
                end
                else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                cmd.rt_step = 1'b1;
                if (cnt_reg == cep_pkg::CNT_W'(cep_pkg::RT_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
                else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/cep_dp.sv
// ---------------------------------------------------------------------------
// Circle event point datapath
// Site table, shared multiply-accumulate, serial dividers, squarer and root.
// ---------------------------------------------------------------------------
module cep_dp (
    input  logic                                  clk,
    input  cep_pkg::cmd_t                         cmd,
    input  logic [cep_pkg::IDX_BITS-1:0]          load_index,
    input  logic signed [cep_pkg::LOAD_BITS-1:0]  load_x,
    input  logic signed [cep_pkg::LOAD_BITS-1:0]  load_y,
    input  logic [cep_pkg::IDX_BITS-1:0]          first_site,
    input  logic [cep_pkg::IDX_BITS-1:0]          second_site,
    input  logic [cep_pkg::IDX_BITS-1:0]          third_site,
    output cep_pkg::status_t                      status,
    output logic signed [cep_pkg::OUT_BITS-1:0]   center_x,
    output logic signed [cep_pkg::OUT_BITS-1:0]   bottom_y,
    output logic                                  degenerate,
    output logic                                  saturated
);

    localparam int CB = cep_pkg::COORD_BITS;

    // Site table
    logic [2*CB-1:0]                   site_mem [cep_pkg::SITE_COUNT];
    logic [2*CB-1:0]                   rd_data_reg;
    logic                              rd_ok_reg;
    logic [cep_pkg::IDX_BITS-1:0]      idx1_reg, idx2_reg, idx3_reg;
    logic [cep_pkg::IDX_BITS-1:0]      rd_idx;
    logic                              load_ok;
    logic [2*CB-1:0]                   site_val;
    logic signed [CB-1:0]              x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;

    // Multiply-accumulate
    logic signed [cep_pkg::DIFF_W-1:0]  dx13, sx13, dy13, sy13, dx21, sx21, dy21, sy21;
    logic signed [cep_pkg::DIFF_W-1:0]  dy31, dx12, dx31, dy12;
    logic signed [cep_pkg::SUMSQ_W-1:0] mul_a;
    logic signed [cep_pkg::DIFF_W-1:0]  mul_b;
    logic signed [cep_pkg::ACC_W-1:0]   prod, acc_base, acc_next, acc_reg;
    logic                               acc_clr, acc_sub;
    logic                               st_s1, st_s2, st_df, st_dg, st_nf, st_ng;
    logic signed [cep_pkg::SUMSQ_W-1:0] s1_reg, s2_reg;
    logic signed [cep_pkg::DEN_W-1:0]   df_reg, dg_reg;
    logic signed [cep_pkg::ACC_W-1:0]   nf_reg, ng_reg;

    // Dividers
    logic [cep_pkg::ACC_W-1:0]          nf_mag, ng_mag;
    logic [cep_pkg::DEN_W-1:0]          df_mag, dg_mag;
    logic [cep_pkg::NUM_W-1:0]          fq_reg, gq_reg;
    logic [cep_pkg::DEN_W-1:0]          fr_reg, gr_reg;
    logic                               fsign_reg, gsign_reg;
    logic [cep_pkg::DEN_W:0]            f_sh, g_sh, f_diff, g_diff;
    logic                               f_ge, g_ge;
    logic signed [cep_pkg::QUO_W-1:0]   fq_ext, gq_ext, h_reg, k_reg;

    // Squarer and root
    logic signed [cep_pkg::EXT_W-1:0]   x1_q, y1_q, ex, ey, ex_neg, ey_neg;
    logic [cep_pkg::MAG_W-1:0]          mx_reg, my_reg, bx_reg, by_reg, px, py;
    logic [cep_pkg::RAD_W-1:0]          rad_reg;
    logic [cep_pkg::REM_W-1:0]          rem_reg, rt_sh, trial, rt_diff;
    logic [cep_pkg::ROOT_W-1:0]         root_reg;
    logic                               rt_ge;

    // Result
    logic signed [cep_pkg::BOT_W-1:0]   h_w, bot;
    logic [cep_pkg::OUT_BITS:0]         cx_c, by_c;
    logic signed [cep_pkg::OUT_BITS-1:0] center_x_reg, bottom_y_reg;
    logic                               degenerate_reg, saturated_reg;

    // ---------------- site table ----------------
    assign load_ok = (32'(load_index) < cep_pkg::SITE_COUNT);

    always_comb
    begin
        case (cmd.rd_site)
            cep_pkg::SITE_FIRST:  rd_idx = idx1_reg;
            cep_pkg::SITE_SECOND: rd_idx = idx2_reg;
            cep_pkg::SITE_THIRD:  rd_idx = idx3_reg;
            default:              rd_idx = idx1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && load_ok) begin
            site_mem[cep_pkg::ADDR_BITS'(load_index)] <= {CB'(load_x), CB'(load_y)};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= site_mem[cep_pkg::ADDR_BITS'(rd_idx)];
            rd_ok_reg   <= (32'(rd_idx) < cep_pkg::SITE_COUNT);
        end
    end

    // an index beyond the table reads as the origin
    assign site_val = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_idx) begin
            idx1_reg <= first_site;
            idx2_reg <= second_site;
            idx3_reg <= third_site;
        end
        if (cmd.cap_en) begin
            case (cmd.cap_site)
                cep_pkg::SITE_FIRST:
                begin
                    x1_reg <= site_val[2*CB-1:CB];
                    y1_reg <= site_val[CB-1:0];
                end
                cep_pkg::SITE_SECOND:
                begin
                    x2_reg <= site_val[2*CB-1:CB];
                    y2_reg <= site_val[CB-1:0];
                end
                cep_pkg::SITE_THIRD:
                begin
                    x3_reg <= site_val[2*CB-1:CB];
                    y3_reg <= site_val[CB-1:0];
                end
                default:
                begin
                    x1_reg <= x1_reg;
                end
            endcase
        end
    end

    // ---------------- multiply-accumulate ----------------
    assign dx13 = cep_pkg::DIFF_W'(x1_reg) - cep_pkg::DIFF_W'(x3_reg);
    assign sx13 = cep_pkg::DIFF_W'(x1_reg) + cep_pkg::DIFF_W'(x3_reg);
    assign dy13 = cep_pkg::DIFF_W'(y1_reg) - cep_pkg::DIFF_W'(y3_reg);
    assign sy13 = cep_pkg::DIFF_W'(y1_reg) + cep_pkg::DIFF_W'(y3_reg);
    assign dx21 = cep_pkg::DIFF_W'(x2_reg) - cep_pkg::DIFF_W'(x1_reg);
    assign sx21 = cep_pkg::DIFF_W'(x2_reg) + cep_pkg::DIFF_W'(x1_reg);
    assign dy21 = cep_pkg::DIFF_W'(y2_reg) - cep_pkg::DIFF_W'(y1_reg);
    assign sy21 = cep_pkg::DIFF_W'(y2_reg) + cep_pkg::DIFF_W'(y1_reg);
    assign dy31 = cep_pkg::DIFF_W'(y3_reg) - cep_pkg::DIFF_W'(y1_reg);
    assign dx12 = cep_pkg::DIFF_W'(x1_reg) - cep_pkg::DIFF_W'(x2_reg);
    assign dx31 = cep_pkg::DIFF_W'(x3_reg) - cep_pkg::DIFF_W'(x1_reg);
    assign dy12 = cep_pkg::DIFF_W'(y1_reg) - cep_pkg::DIFF_W'(y2_reg);

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        acc_clr = 1'b0;
        acc_sub = 1'b0;
        st_s1   = 1'b0;
        st_s2   = 1'b0;
        st_df   = 1'b0;
        st_dg   = 1'b0;
        st_nf   = 1'b0;
        st_ng   = 1'b0;
        case (cmd.mac_op)
            cep_pkg::MAC_S1A:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dx13); mul_b = sx13; acc_clr = 1'b1;
            end
            cep_pkg::MAC_S1B:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dy13); mul_b = sy13; st_s1 = 1'b1;
            end
            cep_pkg::MAC_S2A:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dx21); mul_b = sx21; acc_clr = 1'b1;
            end
            cep_pkg::MAC_S2B:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dy21); mul_b = sy21; st_s2 = 1'b1;
            end
            cep_pkg::MAC_DFA:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dy31); mul_b = dx12; acc_clr = 1'b1;
            end
            cep_pkg::MAC_DFB:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dy21); mul_b = dx13; acc_sub = 1'b1;
                st_df = 1'b1;
            end
            cep_pkg::MAC_DGA:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dx31); mul_b = dy12; acc_clr = 1'b1;
            end
            cep_pkg::MAC_DGB:
            begin
                mul_a = cep_pkg::SUMSQ_W'(dx21); mul_b = dy13; acc_sub = 1'b1;
                st_dg = 1'b1;
            end
            cep_pkg::MAC_NFA:
            begin
                mul_a = s1_reg; mul_b = dx12; acc_clr = 1'b1;
            end
            cep_pkg::MAC_NFB:
            begin
                mul_a = s2_reg; mul_b = dx13; st_nf = 1'b1;
            end
            cep_pkg::MAC_NGA:
            begin
                mul_a = s1_reg; mul_b = dy12; acc_clr = 1'b1;
            end
            cep_pkg::MAC_NGB:
            begin
                mul_a = s2_reg; mul_b = dy13; st_ng = 1'b1;
            end
            default:
            begin
                acc_clr = 1'b1;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign acc_base = acc_clr ? '0 : acc_reg;
    assign acc_next = acc_sub ? (acc_base - prod) : (acc_base + prod);

    always_ff @(posedge clk)
    begin
        if (cmd.mac_en) begin
            acc_reg <= acc_next;
            if (st_s1) s1_reg <= acc_next[cep_pkg::SUMSQ_W-1:0];
            if (st_s2) s2_reg <= acc_next[cep_pkg::SUMSQ_W-1:0];
            if (st_df) df_reg <= {acc_next[cep_pkg::DEN_W-2:0], 1'b0};
            if (st_dg) dg_reg <= {acc_next[cep_pkg::DEN_W-2:0], 1'b0};
            if (st_nf) nf_reg <= acc_next;
            if (st_ng) ng_reg <= acc_next;
        end
    end

    assign status.degen = (df_reg == '0) || (dg_reg == '0);

    // ---------------- restoring dividers, one quotient bit a cycle ----------------
    assign nf_mag = nf_reg[cep_pkg::ACC_W-1] ? -nf_reg : nf_reg;
    assign ng_mag = ng_reg[cep_pkg::ACC_W-1] ? -ng_reg : ng_reg;
    assign df_mag = df_reg[cep_pkg::DEN_W-1] ? -df_reg : df_reg;
    assign dg_mag = dg_reg[cep_pkg::DEN_W-1] ? -dg_reg : dg_reg;

    assign f_sh   = {fr_reg, fq_reg[cep_pkg::NUM_W-1]};
    assign g_sh   = {gr_reg, gq_reg[cep_pkg::NUM_W-1]};
    assign f_diff = f_sh - {1'b0, df_mag};
    assign g_diff = g_sh - {1'b0, dg_mag};
    assign f_ge   = (f_sh >= {1'b0, df_mag});
    assign g_ge   = (g_sh >= {1'b0, dg_mag});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init) begin
            fq_reg    <= {nf_mag, {cep_pkg::FRAC_BITS{1'b0}}};
            gq_reg    <= {ng_mag, {cep_pkg::FRAC_BITS{1'b0}}};
            fr_reg    <= '0;
            gr_reg    <= '0;
            fsign_reg <= nf_reg[cep_pkg::ACC_W-1] ^ df_reg[cep_pkg::DEN_W-1];
            gsign_reg <= ng_reg[cep_pkg::ACC_W-1] ^ dg_reg[cep_pkg::DEN_W-1];
        end
        else if (cmd.div_step) begin
            fr_reg <= f_ge ? f_diff[cep_pkg::DEN_W-1:0] : f_sh[cep_pkg::DEN_W-1:0];
            gr_reg <= g_ge ? g_diff[cep_pkg::DEN_W-1:0] : g_sh[cep_pkg::DEN_W-1:0];
            fq_reg <= {fq_reg[cep_pkg::NUM_W-2:0], f_ge};
            gq_reg <= {gq_reg[cep_pkg::NUM_W-2:0], g_ge};
        end
    end

    // centre is the negated quotient pair: H = -G, K = -F
    assign fq_ext = {1'b0, fq_reg};
    assign gq_ext = {1'b0, gq_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.hk_load) begin
            k_reg <= fsign_reg ? fq_ext : -fq_ext;
            h_reg <= gsign_reg ? gq_ext : -gq_ext;
        end
    end

    // ---------------- radius: serial square-sum then digit-serial root ----------------
    assign x1_q   = cep_pkg::EXT_W'(x1_reg) <<< cep_pkg::FRAC_BITS;
    assign y1_q   = cep_pkg::EXT_W'(y1_reg) <<< cep_pkg::FRAC_BITS;
    assign ex     = x1_q - cep_pkg::EXT_W'(h_reg);
    assign ey     = y1_q - cep_pkg::EXT_W'(k_reg);
    assign ex_neg = -ex;
    assign ey_neg = -ey;

    assign px = bx_reg[cep_pkg::MAG_W-1] ? mx_reg : '0;
    assign py = by_reg[cep_pkg::MAG_W-1] ? my_reg : '0;

    assign rt_sh   = {rem_reg[cep_pkg::REM_W-3:0], rad_reg[cep_pkg::RAD_W-1:cep_pkg::RAD_W-2]};
    assign trial   = cep_pkg::REM_W'({root_reg, 2'b01});
    assign rt_ge   = (rt_sh >= trial);
    assign rt_diff = rt_sh - trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_init) begin
            mx_reg   <= ex[cep_pkg::EXT_W-1] ? ex_neg[cep_pkg::MAG_W-1:0]
                                             : ex[cep_pkg::MAG_W-1:0];
            my_reg   <= ey[cep_pkg::EXT_W-1] ? ey_neg[cep_pkg::MAG_W-1:0]
                                             : ey[cep_pkg::MAG_W-1:0];
            bx_reg   <= ex[cep_pkg::EXT_W-1] ? ex_neg[cep_pkg::MAG_W-1:0]
                                             : ex[cep_pkg::MAG_W-1:0];
            by_reg   <= ey[cep_pkg::EXT_W-1] ? ey_neg[cep_pkg::MAG_W-1:0]
                                             : ey[cep_pkg::MAG_W-1:0];
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_step) begin
            // multiplier bits taken MSB first
            rad_reg <= {rad_reg[cep_pkg::RAD_W-2:0], 1'b0}
                       + cep_pkg::RAD_W'(px) + cep_pkg::RAD_W'(py);
            bx_reg  <= {bx_reg[cep_pkg::MAG_W-2:0], 1'b0};
            by_reg  <= {by_reg[cep_pkg::MAG_W-2:0], 1'b0};
        end
        else if (cmd.rt_step) begin
            rad_reg  <= {rad_reg[cep_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rt_ge ? rt_diff : rt_sh;
            root_reg <= {root_reg[cep_pkg::ROOT_W-2:0], rt_ge};
        end
    end

    // ---------------- result register ----------------
    assign h_w  = cep_pkg::BOT_W'(h_reg);
    assign bot  = cep_pkg::BOT_W'(k_reg) - cep_pkg::BOT_W'(root_reg);
    assign cx_c = cep_pkg::clamp_out(h_w);
    assign by_c = cep_pkg::clamp_out(bot);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            if (status.degen) begin
                center_x_reg   <= '0;
                bottom_y_reg   <= '0;
                degenerate_reg <= 1'b1;
                saturated_reg  <= 1'b0;
            end
            else begin
                center_x_reg   <= cx_c[cep_pkg::OUT_BITS-1:0];
                bottom_y_reg   <= by_c[cep_pkg::OUT_BITS-1:0];
                degenerate_reg <= 1'b0;
                saturated_reg  <= cx_c[cep_pkg::OUT_BITS] | by_c[cep_pkg::OUT_BITS];
            end
        end
    end

    assign center_x   = center_x_reg;
    assign bottom_y   = bottom_y_reg;
    assign degenerate = degenerate_reg;
    assign saturated  = saturated_reg;

endmodule

>>> design/circle_event_point_core.sv
// ---------------------------------------------------------------------------
// Circle event point core
// Lowest point of the circle through three stored sites, in signed Q24.8.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall): operation selects a load, which writes
// load_x/load_y to entry load_index and gives no result, or an evaluate,
// which reads entries first_site, second_site and third_site.
// Loads are taken back to back; an evaluate holds in_stall high until its
// result has been moved to the output register.
// An evaluate steps through the table reads, the shared multiplier, a check
// for degenerate sites, the bit-serial dividers, the centre load, the square
// sum and the root, then loads the result; collinear sites go from the check
// straight to the result. A new evaluate is taken only after the last one has
// reached the output register; the bit-serial dividers, squarer and root serve
// one evaluate at a time.
// Output channel (out_valid/out_stall): one transaction per evaluate. While
// the receiver stalls, the result holds; the next evaluate may run and waits
// at its end for the output register.
// Reset clears control only; the site table is undefined until loaded.
// ---------------------------------------------------------------------------
module circle_event_point_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [cep_pkg::IDX_BITS-1:0]          load_index,
    input  logic signed [cep_pkg::LOAD_BITS-1:0]  load_x,
    input  logic signed [cep_pkg::LOAD_BITS-1:0]  load_y,
    input  logic [cep_pkg::IDX_BITS-1:0]          first_site,
    input  logic [cep_pkg::IDX_BITS-1:0]          second_site,
    input  logic [cep_pkg::IDX_BITS-1:0]          third_site,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [cep_pkg::OUT_BITS-1:0]   center_x,
    output logic signed [cep_pkg::OUT_BITS-1:0]   bottom_y,
    output logic                                  degenerate,
    output logic                                  saturated
);

    cep_pkg::cmd_t    cmd;
    cep_pkg::status_t status;

    cep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    cep_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .load_index  (load_index),
        .load_x      (load_x),
        .load_y      (load_y),
        .first_site  (first_site),
        .second_site (second_site),
        .third_site  (third_site),
        .status      (status),
        .center_x    (center_x),
        .bottom_y    (bottom_y),
        .degenerate  (degenerate),
        .saturated   (saturated)
    );

endmodule

>>> design/cep_checker.sv
// ---------------------------------------------------------------------------
// Circle event point port checker
// Port-level properties of the core, bound to the top level.
// ---------------------------------------------------------------------------
`include "circle_event_point_core_macros.svh"

module cep_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  operation,
    input  logic [cep_pkg::IDX_BITS-1:0]          load_index,
    input  logic signed [cep_pkg::LOAD_BITS-1:0]  load_x,
    input  logic signed [cep_pkg::LOAD_BITS-1:0]  load_y,
    input  logic [cep_pkg::IDX_BITS-1:0]          first_site,
    input  logic [cep_pkg::IDX_BITS-1:0]          second_site,
    input  logic [cep_pkg::IDX_BITS-1:0]          third_site,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [cep_pkg::OUT_BITS-1:0]   center_x,
    input  logic signed [cep_pkg::OUT_BITS-1:0]   bottom_y,
    input  logic                                  degenerate,
    input  logic                                  saturated
);

    `CEP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    `CEP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(center_x) && $stable(bottom_y) && $stable(degenerate) && $stable(saturated), "stalled result changed")

    `CEP_ASSERT_SAME(a_degen_zero, out_valid && degenerate, center_x == '0 && bottom_y == '0 && !saturated, "degenerate result not zero")

    `CEP_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && operation == cep_pkg::OP_EVAL, in_stall, "evaluate accepted without going busy")

endmodule

bind circle_event_point_core cep_checker u_checker (.*);

>>> tb/circle_event_point_checker.sv
// ---------------------------------------------------------------------------
// Circle event point checker
// Watches both channels, tracks the site table, works out the circumcircle
// lowest point of every evaluate and compares it with the block's result.
// ---------------------------------------------------------------------------
module circle_event_point_checker
    import cep_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        operation,
    input  logic [IDX_BITS-1:0]         load_index,
    input  logic signed [LOAD_BITS-1:0] load_x,
    input  logic signed [LOAD_BITS-1:0] load_y,
    input  logic [IDX_BITS-1:0]         first_site,
    input  logic [IDX_BITS-1:0]         second_site,
    input  logic [IDX_BITS-1:0]         third_site,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [OUT_BITS-1:0]  center_x,
    input  logic signed [OUT_BITS-1:0]  bottom_y,
    input  logic                        degenerate,
    input  logic                        saturated,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] cx;
        logic signed [OUT_BITS-1:0] by;
        logic                       degen;
        logic                       sat;
    } circle_point_t;

    logic signed [LOAD_BITS-1:0] site_x [SITE_COUNT];
    logic signed [LOAD_BITS-1:0] site_y [SITE_COUNT];
    circle_point_t               circle_points [$];

    function automatic wide_t floor_root(input wide_t n);
        logic [255:0] res;
        logic [255:0] trial;
        res = '0;
        for (int i = 127; i >= 0; i--)
        begin
            trial = res | (256'd1 << i);
            if (trial * trial <= n)
                res = trial;
        end
        return wide_t'(res);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] clamp32(input wide_t v, inout logic sat);
        if (v > 2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -wide_t'(64'sd2147483648))
        begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[OUT_BITS-1:0];
    endfunction

    function automatic circle_point_t lowest_point(input logic [IDX_BITS-1:0] a,
                                                   input logic [IDX_BITS-1:0] b,
                                                   input logic [IDX_BITS-1:0] c);
        wide_t x1, y1, x2, y2, x3, y3;
        wide_t s1, s2, df, dg, nf, ng, f, g, h, k, ex, ey, rad;
        circle_point_t p;
        x1 = wide_t'(site_x[a]); y1 = wide_t'(site_y[a]);
        x2 = wide_t'(site_x[b]); y2 = wide_t'(site_y[b]);
        x3 = wide_t'(site_x[c]); y3 = wide_t'(site_y[c]);
        s1 = (x1 * x1 - x3 * x3) + (y1 * y1 - y3 * y3);
        s2 = (x2 * x2 - x1 * x1) + (y2 * y2 - y1 * y1);
        df = 2 * ((y3 - y1) * (x1 - x2) - (y2 - y1) * (x1 - x3));
        dg = 2 * ((x3 - x1) * (y1 - y2) - (x2 - x1) * (y1 - y3));
        p.sat = 1'b0;
        if (df == 0 || dg == 0)
        begin
            p.cx = '0;
            p.by = '0;
            p.degen = 1'b1;
            return p;
        end
        nf = s1 * (x1 - x2) + s2 * (x1 - x3);
        ng = s1 * (y1 - y2) + s2 * (y1 - y3);
        // signed division here truncates toward zero
        f = (nf * 256) / df;
        g = (ng * 256) / dg;
        h = -g;
        k = -f;
        ex = x1 * 256 - h;
        ey = y1 * 256 - k;
        rad = floor_root(ex * ex + ey * ey);
        p.degen = 1'b0;
        p.cx = clamp32(h, p.sat);
        p.by = clamp32(k - rad, p.sat);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        circle_point_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (operation == OP_LOAD)
                begin
                    site_x[load_index] = load_x;
                    site_y[load_index] = load_y;
                end
                else
                    circle_points.insert(circle_points.size(),
                                         lowest_point(first_site, second_site, third_site));
            end
            if (out_valid && !out_stall)
            begin
                if (circle_points.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with no evaluate outstanding", $realtime);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = circle_points.pop_front();
                    if (want.cx !== center_x || want.by !== bottom_y
                        || want.degen !== degenerate || want.sat !== saturated)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp cx=%0d by=%0d dg=%b st=%b got cx=%0d by=%0d dg=%b st=%b",
                                     $realtime, want.cx, want.by, want.degen, want.sat,
                                     center_x, bottom_y, degenerate, saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= circle_points.size();
        end
    end

endmodule

>>> tb/tb_circle_event_point_core.sv
// ---------------------------------------------------------------------------
// Circle event point core testbench
// Loads sites and evaluates triples, directed corners first and then random
// traffic in bursts against a stalling receiver; the checker scores results.
// ---------------------------------------------------------------------------
module tb_circle_event_point_core;
    import cep_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_COUNT = 1700;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        operation;
    logic [IDX_BITS-1:0]         load_index;
    logic signed [LOAD_BITS-1:0] load_x;
    logic signed [LOAD_BITS-1:0] load_y;
    logic [IDX_BITS-1:0]         first_site;
    logic [IDX_BITS-1:0]         second_site;
    logic [IDX_BITS-1:0]         third_site;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [OUT_BITS-1:0]  center_x;
    logic signed [OUT_BITS-1:0]  bottom_y;
    logic                        degenerate;
    logic                        saturated;
    int                          fail_count;
    int                          pending;
    logic                        in_took;
    int                          idle_cycles;
    int                          burst_left;
    logic                        loaded [SITE_COUNT];

    circle_event_point_core u_top (.*);

    circle_event_point_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver stalls in phases: none, light, heavy
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(50, 600))
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    default: out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input op_t op, input logic [IDX_BITS-1:0] idx,
                             input logic signed [LOAD_BITS-1:0] lx,
                             input logic signed [LOAD_BITS-1:0] ly,
                             input logic [IDX_BITS-1:0] a, input logic [IDX_BITS-1:0] b,
                             input logic [IDX_BITS-1:0] c);
        int gap;
        operation = op;
        load_index = idx;
        load_x = lx;
        load_y = ly;
        first_site = a;
        second_site = b;
        third_site = c;
        in_valid = 1'b1;
        do
            @(negedge clk);
        while (!in_took);
        if (op == OP_LOAD)
            loaded[idx] = 1'b1;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    function automatic logic [IDX_BITS-1:0] pick_loaded();
        logic [IDX_BITS-1:0] i;
        do
            i = IDX_BITS'($urandom_range(0, SITE_COUNT - 1));
        while (!loaded[i]);
        return i;
    endfunction

    task automatic load_site(input logic [IDX_BITS-1:0] idx, input int x, input int y);
        send_item(OP_LOAD, idx, LOAD_BITS'(x), LOAD_BITS'(y), IDX_BITS'($urandom),
                  IDX_BITS'($urandom), IDX_BITS'($urandom));
    endtask

    task automatic evaluate(input logic [IDX_BITS-1:0] a, input logic [IDX_BITS-1:0] b,
                            input logic [IDX_BITS-1:0] c);
        send_item(OP_EVAL, IDX_BITS'($urandom), LOAD_BITS'($urandom), LOAD_BITS'($urandom),
                  a, b, c);
    endtask

    initial
    begin
        logic [IDX_BITS-1:0] a;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        load_index = '0;
        load_x = '0;
        load_y = '0;
        first_site = '0;
        second_site = '0;
        third_site = '0;
        burst_left = 0;
        foreach (loaded[i])
            loaded[i] = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corners: extreme coordinates, collinear, repeated and far-off centres
        load_site(0, -32768, -32768);
        load_site(255, 32767, 32767);
        load_site(1, 32767, -32768);
        load_site(2, -32768, 32767);
        load_site(3, 0, 0);
        load_site(4, 1, 0);
        load_site(5, 0, 1);
        load_site(6, 2, 0);
        load_site(7, 32767, 32766);
        evaluate(3, 4, 5);
        evaluate(3, 4, 6);
        evaluate(0, 0, 1);
        evaluate(0, 255, 7);
        evaluate(0, 1, 2);
        evaluate(1, 2, 255);
        evaluate(255, 1, 0);
        evaluate(5, 5, 5);

        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                a = IDX_BITS'($urandom_range(0, SITE_COUNT - 1));
                if ($urandom_range(0, 1) == 0)
                    load_site(a, $urandom_range(0, 65535) - 32768,
                              $urandom_range(0, 65535) - 32768);
                else
                    load_site(a, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
            end
            else
            begin
                a = pick_loaded();
                if ($urandom_range(0, 9) == 0)
                    evaluate(a, a, pick_loaded());
                else
                    evaluate(a, pick_loaded(), pick_loaded());
            end
        end
        in_valid = 1'b0;

        // let the last evaluate clear the output register, then drain
        repeat (4) @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/cep_pkg.sv
design/cep_ctrl.sv
design/cep_dp.sv
design/circle_event_point_core.sv
design/cep_checker.sv
tb/circle_event_point_checker.sv
tb/tb_circle_event_point_core.sv
